[design/bidirectional_flow_table_macros.svh]
// assertion helpers
`ifndef BIDIRECTIONAL_FLOW_TABLE_MACROS_SVH
`define BIDIRECTIONAL_FLOW_TABLE_MACROS_SVH
`define BFT_ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define BFT_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

[design/bft_pkg.sv]
`default_nettype none
package bft_pkg;
	localparam logic [1:0] ACT_PACKET = 2'd0;
	localparam logic [1:0] ACT_SCAN   = 2'd1;
	localparam logic [1:0] ACT_DELETE = 2'd2;
	localparam logic [1:0] ACT_NONE   = 2'd3;
	localparam logic [1:0] KIND_PACKET  = 2'd0;
	localparam logic [1:0] KIND_EXPIRED = 2'd1;
	localparam logic [1:0] KIND_SCAN    = 2'd2;
	localparam logic [1:0] KIND_DELETE  = 2'd3;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam int PORT_SHIFT = 16;
	localparam logic [31:0] TIMEOUT_RESET = 32'd30;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] src_ip;
		logic [15:0] src_port;
		logic [31:0] dst_ip;
		logic [15:0] dst_port;
		logic [7:0]  protocol;
		logic [31:0] now_secs;
		logic [5:0]  scan_count;
		logic [9:0]  target_entry;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [9:0]  entry_index;
		logic        hit;
		logic        created;
		logic        table_full;
		logic        direction;
		logic [31:0] north_count;
		logic [31:0] south_count;
		logic [5:0]  expired_count;
		logic        last;
	} out_word_t;

	// classified command from front to back
	typedef struct packed {
		logic [1:0]  action;
		logic [47:0] lo;
		logic [47:0] hi;
		logic [7:0]  protocol;
		logic        direction;
		logic [31:0] now_secs;
		logic [5:0]  scan_count;
		logic [9:0]  target_entry;
	} cmd_t;
endpackage
`default_nettype wire

[design/bft_if.sv]
`default_nettype none
interface bft_in_if;
	import bft_pkg::*;
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bft_out_if;
	import bft_pkg::*;
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/bft_ram.sv]
`default_nettype none
module bft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[design/bft_front.sv]
`default_nettype none
module bft_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	bft_in_if.sink             in_ch,
	output logic               cmd_valid,
	output bft_pkg::cmd_t      cmd,
	input  wire logic          cmd_ready
);
	import bft_pkg::*;
	// two-entry queue
	cmd_t q_q [2];
	logic [1:0] cnt_q;
	logic rd_q;
	logic [47:0] s, d;
	logic l4, dir;
	cmd_t c;
	logic push, pop;

	always_comb begin
		l4 = in_ch.data.protocol == PROTO_TCP || in_ch.data.protocol == PROTO_UDP;
		s = {in_ch.data.src_ip, (l4 ? in_ch.data.src_port : 16'd0)};
		d = {in_ch.data.dst_ip, (l4 ? in_ch.data.dst_port : 16'd0)};
		dir = s > d;
		c.action = in_ch.data.action;
		c.lo = dir ? d : s;
		c.hi = dir ? s : d;
		c.protocol = in_ch.data.protocol;
		c.direction = dir;
		c.now_secs = in_ch.data.now_secs;
		c.scan_count = in_ch.data.scan_count;
		c.target_entry = in_ch.data.target_entry;
	end

	assign in_ch.ready = cnt_q != 2'd2;
	assign push = in_ch.valid && in_ch.ready && in_ch.data.action != ACT_NONE;
	assign cmd_valid = cnt_q != 2'd0;
	assign pop = cmd_valid && cmd_ready;
	assign cmd = q_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) q_q[rd_q ^ cnt_q[0]] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			if (pop) rd_q <= ~rd_q;
		end
	end
endmodule
`default_nettype wire

[design/bft_back.sv]
`default_nettype none
`include "bidirectional_flow_table_macros.svh"
module bft_back #(
	parameter int TABLE_ENTRIES = 1024
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [31:0]   cfg_wdata,
	input  wire logic          cmd_valid,
	input  wire bft_pkg::cmd_t cmd,
	output logic               cmd_ready,
	bft_out_if.source          out_ch
);
	import bft_pkg::*;
	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int KW = 104;
	localparam int RW = KW + 97;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_SEARCH, ST_SCAN, ST_SCAN_CHK, ST_EMIT
	} state_t;
	state_t state_q, ret_q;

	logic [31:0] timeout_q;
	logic [AW-1:0] cursor_q, idx_q, free_q, rd_idx_q;
	logic free_found_q, rd_pend_q;
	cmd_t cmd_q;
	logic [5:0] seen_q, exp_q;
	out_word_t res_q, out_q;
	logic out_valid_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [RW-1:0] wdata, rdata;
	logic [KW-1:0] key;
	logic [31:0] n_nc, n_sc;
	logic [32:0] lim;
	logic last_slot, is_del, del_ok, hit_now, at_end, slot_free, new_ok, expired;
	logic search_go, emit_fire, res_load;
	logic [AW-1:0] new_slot;
	out_word_t res_d;

	// record: valid, key, north, south, created
	bft_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign key = {cmd_q.lo, cmd_q.hi, cmd_q.protocol};
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;
	assign cmd_ready = state_q == ST_IDLE;
	assign raddr = idx_q;

	always_comb begin
		n_nc = rdata[95:64] + 32'(!cmd_q.direction);
		n_sc = rdata[63:32] + 32'(cmd_q.direction);
		lim = {1'b0, rdata[31:0]} + {1'b0, timeout_q};
		expired = rdata[RW-1] && ({1'b0, cmd_q.now_secs} > lim);
		last_slot = idx_q == AW'(TABLE_ENTRIES - 1);
		is_del = state_q == ST_IDLE && cmd_valid && cmd.action != ACT_PACKET
			&& cmd.action != ACT_SCAN;
		del_ok = 32'(cmd.target_entry) < 32'(TABLE_ENTRIES);
		hit_now = state_q == ST_SEARCH && rd_pend_q && rdata[RW-1]
			&& rdata[RW-2:96] == key;
		at_end = state_q == ST_SEARCH && rd_pend_q
			&& rd_idx_q == AW'(TABLE_ENTRIES - 1);
		slot_free = rd_pend_q && !rdata[RW-1];
		new_ok = free_found_q || slot_free;
		new_slot = free_found_q ? free_q : rd_idx_q;
		search_go = state_q == ST_SEARCH && !hit_now && !at_end;
		emit_fire = state_q == ST_EMIT && (!out_valid_q || out_ch.ready);
	end

	always_comb begin
		we = 1'b0;
		waddr = idx_q;
		wdata = '0;
		if (state_q == ST_CLEAR) begin
			we = 1'b1;
		end else if (is_del && del_ok) begin
			we = 1'b1;
			waddr = AW'(cmd.target_entry);
		end else if (hit_now) begin
			we = 1'b1;
			waddr = rd_idx_q;
			wdata = {1'b1, key, n_nc, n_sc, rdata[31:0]};
		end else if (at_end && new_ok) begin
			we = 1'b1;
			waddr = new_slot;
			wdata = {1'b1, key, 32'(!cmd_q.direction), 32'(cmd_q.direction),
				cmd_q.now_secs};
		end
	end

	always_comb begin
		res_d = '0;
		res_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (is_del) begin
					res_load = 1'b1;
					res_d.kind = KIND_DELETE;
					res_d.entry_index = cmd.target_entry;
					res_d.last = 1'b1;
				end
			end
			ST_SEARCH: begin
				if (hit_now || at_end) begin
					res_load = 1'b1;
					res_d.kind = KIND_PACKET;
					res_d.direction = cmd_q.direction;
					res_d.last = 1'b1;
					if (hit_now) begin
						res_d.entry_index = 10'(rd_idx_q);
						res_d.hit = 1'b1;
						res_d.north_count = n_nc;
						res_d.south_count = n_sc;
					end else if (new_ok) begin
						res_d.entry_index = 10'(new_slot);
						res_d.created = 1'b1;
						res_d.north_count = 32'(!cmd_q.direction);
						res_d.south_count = 32'(cmd_q.direction);
					end else res_d.table_full = 1'b1;
				end
			end
			ST_SCAN: begin
				if (seen_q == cmd_q.scan_count) begin
					res_load = 1'b1;
					res_d.kind = KIND_SCAN;
					res_d.expired_count = exp_q;
					res_d.last = 1'b1;
				end
			end
			ST_SCAN_CHK: begin
				if (expired) begin
					res_load = 1'b1;
					res_d.kind = KIND_EXPIRED;
					res_d.entry_index = 10'(idx_q);
					res_d.north_count = rdata[95:64];
					res_d.south_count = rdata[63:32];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) cmd_q <= cmd;
		if (res_load) res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ret_q <= ST_IDLE;
			timeout_q <= TIMEOUT_RESET;
			cursor_q <= '0;
			idx_q <= '0;
			free_q <= '0;
			rd_idx_q <= '0;
			free_found_q <= 1'b0;
			rd_pend_q <= 1'b0;
			seen_q <= '0;
			exp_q <= '0;
			out_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) timeout_q <= cfg_wdata;
			rd_pend_q <= search_go;
			out_valid_q <= emit_fire || (out_valid_q && !out_ch.ready);
			if (emit_fire) out_q <= res_q;
			case (state_q)
				// clearing pass over every slot
				ST_CLEAR: begin
					idx_q <= last_slot ? '0 : idx_q + 1'b1;
					if (last_slot) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						case (cmd.action)
							ACT_PACKET: begin
								idx_q <= '0;
								free_found_q <= 1'b0;
								state_q <= ST_SEARCH;
							end
							ACT_SCAN: begin
								idx_q <= cursor_q;
								seen_q <= '0;
								exp_q <= '0;
								state_q <= ST_SCAN;
							end
							default: begin
								ret_q <= ST_IDLE;
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				// one slot a cycle, read data comes from the registered RAM output
				ST_SEARCH: begin
					if (hit_now || at_end) begin
						ret_q <= ST_IDLE;
						state_q <= ST_EMIT;
					end else begin
						if (slot_free && !free_found_q) begin
							free_found_q <= 1'b1;
							free_q <= rd_idx_q;
						end
						rd_idx_q <= idx_q;
						idx_q <= last_slot ? '0 : idx_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (seen_q == cmd_q.scan_count) begin
						cursor_q <= idx_q;
						ret_q <= ST_IDLE;
						state_q <= ST_EMIT;
					end else state_q <= ST_SCAN_CHK;
				end
				ST_SCAN_CHK: begin
					idx_q <= last_slot ? '0 : idx_q + 1'b1;
					if (last_slot) seen_q <= cmd_q.scan_count;
					else if (rdata[RW-1]) seen_q <= seen_q + 1'b1;
					if (expired) begin
						exp_q <= exp_q + 1'b1;
						ret_q <= ST_SCAN;
						state_q <= ST_EMIT;
					end else state_q <= ST_SCAN;
				end
				ST_EMIT: begin
					if (emit_fire) state_q <= ret_q;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`BFT_ASSERT_NEXT(a_emit_valid, clk, arst_n, emit_fire, out_valid_q)
	`BFT_ASSERT_NEXT(a_out_hold, clk, arst_n,
		out_valid_q && !out_ch.ready, out_valid_q && $stable(out_q))
	`BFT_ASSERT_IMPL(a_ready_idle, clk, arst_n, cmd_ready, state_q == ST_IDLE)
	`BFT_ASSERT_IMPL(a_full_flags, clk, arst_n,
		out_valid_q && out_q.table_full, !out_q.hit && !out_q.created)
endmodule
`default_nettype wire

[design/bidirectional_flow_table.sv]
// channel  dir  contents
// in_ch    in   action, tuple, now_secs, scan_count, target_entry
// out_ch   out  kind, entry_index, flags, counts, expired_count, last
// cfg      in   timeout_secs write
// a new flow or a full table reads every slot in the back: one slot read per cycle
// a hit on slot k ends the search at slot k, a delete writes its target slot without a search
// a scan passes ST_SCAN and ST_SCAN_CHK for each slot passed or examined, and ST_EMIT per expired word
// after reset a clearing pass over every slot runs before the first command
// a held result stalls the back, a two-word queue lets the front keep accepting
`default_nettype none
module bidirectional_flow_table #(
	parameter int TABLE_ENTRIES = 1024
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_we,
	input wire logic [31:0] cfg_wdata,
	bft_in_if.sink          in_ch,
	bft_out_if.source       out_ch
);
	import bft_pkg::*;
	logic cmd_valid, cmd_ready;
	cmd_t cmd;

	bft_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_ready(cmd_ready)
	);

	bft_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_ready(cmd_ready), .out_ch(out_ch)
	);
endmodule
`default_nettype wire
